>>> hdl/ftb_pkg.sv
// Shared types and constants for the binary indexed tree block.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package ftb_pkg;

  // Fixed field widths of the transaction payloads and the size register.
  localparam int POS_W  = 11;
  localparam int SUM_W  = 32;
  // The tree walk can step past the largest position by up to one low bit.
  localparam int WALK_W = POS_W + 1;

  localparam int DEFAULT_MAX_LEAVES = 1024;
  localparam logic [POS_W-1:0] LEAVES_RESET = 11'd1024;

  // Command codes carried in the input transaction.
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Request strobes from the sequencer to the partial sum table.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } ftb_mem_ctl_t;

endpackage

`default_nettype wire

>>> hdl/ftb_if.sv
// Valid/ready channel interfaces for command and result transactions.
// Depends on ftb_pkg for the payload widths.
`default_nettype none

interface ftb_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  command;
  logic        [ftb_pkg::POS_W-1:0]      position;
  logic signed [ftb_pkg::SUM_W-1:0]      amount;

  modport source (output valid, command, position, amount, input ready);
  modport sink   (input valid, command, position, amount, output ready);
endinterface

interface ftb_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [ftb_pkg::SUM_W-1:0]      prefix_total;

  modport source (output valid, prefix_total, input ready);
  modport sink   (input valid, prefix_total, output ready);
endinterface

`default_nettype wire

>>> hdl/ftb_table.sv
// Partial sum table: single-port synchronous memory with a registered read
// and a zeroing sweep after reset. Depends on ftb_pkg.
`default_nettype none

module ftb_table #(
  parameter int DEPTH = ftb_pkg::DEFAULT_MAX_LEAVES
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire ftb_pkg::ftb_mem_ctl_t         ctl,
  input  wire logic [$clog2(DEPTH)-1:0]      addr,
  input  wire logic [ftb_pkg::SUM_W-1:0]     wdata,
  output      logic [ftb_pkg::SUM_W-1:0]     rdata,
  output      logic                          busy
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [ftb_pkg::SUM_W-1:0] mem [DEPTH];
  logic [AW-1:0]             clr_idx_r;
  logic                      clr_busy_r;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic [ftb_pkg::SUM_W-1:0] wr_data;

  // The sweep owns the write port until every entry holds zero.
  always_comb begin
    if (clr_busy_r) begin
      wr_en   = 1'b1;
      wr_addr = clr_idx_r;
      wr_data = '0;
    end else begin
      wr_en   = ctl.wr_en;
      wr_addr = addr;
      wr_data = wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r  <= '0;
      clr_busy_r <= 1'b1;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + AW'(1);
      if (clr_idx_r == LAST) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rdata <= mem[addr];
    end
  end

  assign busy = clr_busy_r;

endmodule

`default_nettype wire

>>> hdl/fenwick_tree_update_prefix_sum.sv
// Top level of the binary indexed tree: command sequencer, size register
// and result register. Depends on ftb_pkg, ftb_if.sv and ftb_table.
//
//  Channel   Dir   Protocol      Payload
//  in_item   in    valid/ready   command, position, amount
//  out_item  out   valid/ready   prefix_total
//  cfg_*     in    write only    leaves_in_use (11 bits)
//
// Each tree node has a memory read state, then an accumulate or write-back
// state, and the memory port is the limit. A query ends in a further state
// that loads the result. At 1024 leaves an add walks at most eleven nodes
// and a query at most ten. After reset the table is zeroed one entry per
// cycle, with in_item.ready low; configuration writes are taken meanwhile.
// A finished query waits in its last state while out_item is stalled; a
// result already held in the output register does not block a new command.
`default_nettype none

module fenwick_tree_update_prefix_sum #(
  parameter int MAX_LEAVES = ftb_pkg::DEFAULT_MAX_LEAVES
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  ftb_in_if.sink                          in_item,
  ftb_out_if.source                       out_item,
  input  wire logic                       cfg_wr_en,
  input  wire logic [ftb_pkg::POS_W-1:0]  cfg_wr_data
);

  localparam int AW = $clog2(MAX_LEAVES);
  localparam int EW = (AW > ftb_pkg::WALK_W) ? AW : ftb_pkg::WALK_W;
  // The size register is 11 bits wide, so a larger table caps nothing.
  localparam int SIZE_CAP = (MAX_LEAVES > 2047) ? 2047 : MAX_LEAVES;
  localparam logic [ftb_pkg::POS_W-1:0] SIZE_CAP_W = ftb_pkg::POS_W'(SIZE_CAP);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_UPD,
    ST_FIN
  } state_t;

  state_t                        state_r;
  logic                          cmd_r;
  logic [ftb_pkg::WALK_W-1:0]    walk_r;
  logic [ftb_pkg::SUM_W-1:0]     amount_r;
  logic [ftb_pkg::SUM_W-1:0]     total_r;
  logic                          out_valid_r;
  logic [ftb_pkg::SUM_W-1:0]     out_total_r;
  logic [ftb_pkg::POS_W-1:0]     leaves_r;

  logic [ftb_pkg::POS_W-1:0]     size_now;
  logic [ftb_pkg::POS_W-1:0]     query_pos;
  logic [ftb_pkg::WALK_W-1:0]    low_bit;
  logic [ftb_pkg::WALK_W-1:0]    walk_up;
  logic [ftb_pkg::WALK_W-1:0]    walk_down;
  logic [EW-1:0]                 addr_wide;
  logic [AW-1:0]                 mem_addr;
  logic [ftb_pkg::SUM_W-1:0]     rd_data;
  logic [ftb_pkg::SUM_W-1:0]     wr_data;
  logic                          clear_busy;
  logic                          in_fire;
  logic                          out_free;
  logic                          out_load;
  ftb_pkg::ftb_mem_ctl_t         mem_ctl;

  // Size register. User writes only while the block is idle; not enforced.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leaves_r <= ftb_pkg::LEAVES_RESET;
    end else if (cfg_wr_en) begin
      leaves_r <= cfg_wr_data;
    end
  end

  assign size_now  = (leaves_r > SIZE_CAP_W) ? SIZE_CAP_W : leaves_r;
  assign query_pos = (in_item.position > size_now) ? size_now : in_item.position;

  // Node walk: the add walks up by the low bit, the query walks down.
  assign low_bit   = walk_r & (~walk_r + ftb_pkg::WALK_W'(1));
  assign walk_up   = walk_r + low_bit;
  assign walk_down = walk_r - low_bit;

  // Positions are 1-based; the table entry is position minus one.
  assign addr_wide = EW'(walk_r) - EW'(1);
  assign mem_addr  = addr_wide[AW-1:0];
  assign wr_data   = rd_data + amount_r;

  assign mem_ctl.rd_en = (state_r == ST_RD);
  assign mem_ctl.wr_en = (state_r == ST_UPD) && (cmd_r == ftb_pkg::CMD_ADD);

  ftb_table #(
    .DEPTH (MAX_LEAVES)
  ) u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mem_ctl),
    .addr  (mem_addr),
    .wdata (wr_data),
    .rdata (rd_data),
    .busy  (clear_busy)
  );

  assign in_item.ready = (state_r == ST_IDLE) && !clear_busy;
  assign in_fire       = in_item.valid && in_item.ready;
  assign out_free      = !out_valid_r || out_item.ready;
  // A finished query moves its total into the output register.
  assign out_load      = (state_r == ST_FIN) && out_free;

  // Sequencer. A write-back finishes before the next read can start, so
  // successive transactions never see a stale entry and need no forwarding.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_item.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            cmd_r    <= in_item.command;
            amount_r <= unsigned'(in_item.amount);
            total_r  <= '0;
            if (in_item.command == ftb_pkg::CMD_ADD) begin
              walk_r <= ftb_pkg::WALK_W'(in_item.position);
              // An add at zero or beyond the size touches no node.
              if (in_item.position != '0 && in_item.position <= size_now) begin
                state_r <= ST_RD;
              end
            end else begin
              walk_r  <= ftb_pkg::WALK_W'(query_pos);
              state_r <= (query_pos == '0) ? ST_FIN : ST_RD;
            end
          end
        end
        ST_RD: begin
          state_r <= ST_UPD;
        end
        ST_UPD: begin
          if (cmd_r == ftb_pkg::CMD_ADD) begin
            walk_r  <= walk_up;
            state_r <= (walk_up > ftb_pkg::WALK_W'(size_now)) ? ST_IDLE : ST_RD;
          end else begin
            total_r <= total_r + rd_data;
            walk_r  <= walk_down;
            state_r <= (walk_down == '0) ? ST_FIN : ST_RD;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_total_r <= total_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_item.valid        = out_valid_r;
  assign out_item.prefix_total = signed'(out_total_r);

`ifndef SYNTH
  // No command is taken while the table is still being zeroed.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clear_busy |-> !in_item.ready)
    else $error("command accepted during table clear");

  // Only an add writes the table, and only after its read.
  a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    mem_ctl.wr_en |-> $past(mem_ctl.rd_en) && cmd_r == ftb_pkg::CMD_ADD)
    else $error("table write without a preceding read of an add");

  // A read never addresses position zero.
  a_walk_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RD |-> walk_r != '0)
    else $error("tree walk reached position zero");

  // A result appears only when a query finishes.
  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FIN)
    else $error("result produced outside query completion");
`endif

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for fenwick_tree_update_prefix_sum: random and directed
// add and prefix commands, checked against a behavioral tree kept alongside.
// Depends on ftb_pkg, the channel interfaces in ftb_if.sv and the block itself.
`timescale 1ns / 1ps

module testbench;

  localparam int TREE_LEAVES = ftb_pkg::DEFAULT_MAX_LEAVES;
  // An add walks at most eleven nodes and a query at most ten, so a pause
  // of this many cycles covers any add still in flight after the last result.
  localparam int DRAIN_CYCLES = 40;
  // Length of the deliberate hold-off on the result channel.
  localparam int HOLD_CYCLES = 300;

  // One command transaction as it travels on the input channel.
  typedef struct {
    logic                       command;
    logic [ftb_pkg::POS_W-1:0]  position;
    logic [ftb_pkg::SUM_W-1:0]  amount;
  } tree_cmd_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [ftb_pkg::POS_W-1:0] cfg_wr_data;

  ftb_in_if  in_ch ();
  ftb_out_if out_ch ();

  fenwick_tree_update_prefix_sum dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_item     (in_ch),
    .out_item    (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Behavioral copy of the tree: the table of partial sums and the size
  // register. Both persist across size changes, exactly as in the block.
  logic [ftb_pkg::SUM_W-1:0] sums_model [TREE_LEAVES];
  logic [ftb_pkg::POS_W-1:0] leaves_model;

  tree_cmd_t                 pending_cmds [$];
  logic [ftb_pkg::SUM_W-1:0] expected_totals [$];
  int                        error_count = 0;

  // Sender burst state, receiver stall state and the long hold-off.
  int          burst_left = 0;
  int          gap_left = 0;
  logic [15:0] stall_pattern = 16'hFFFF;
  int          stall_age = 0;
  int          hold_left = 0;
  int          pressure_requests = 0;
  int          pressure_served = 0;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    error_count++;
  endtask

  // A size above MAX_LEAVES acts as MAX_LEAVES.
  function automatic int span_in_use();
    return (leaves_model > TREE_LEAVES) ? TREE_LEAVES : int'(leaves_model);
  endfunction

  // Applies one accepted transaction to the model. An add climbs the tree
  // through p, p + lowbit(p), ... while inside the span; a query descends
  // through p, p - lowbit(p), ... after clamping to the span, and its wrapped
  // total is queued as the next expected result.
  task automatic tree_apply(input tree_cmd_t c);
    int                        span;
    int                        p;
    logic [ftb_pkg::SUM_W-1:0] total;
    span = span_in_use();
    p = int'(c.position);
    if (c.command == ftb_pkg::CMD_ADD) begin
      if (p != 0) begin
        while (p <= span) begin
          sums_model[p-1] = sums_model[p-1] + c.amount;
          p += p & -p;
        end
      end
    end else begin
      total = '0;
      if (p > span)
        p = span;
      while (p > 0) begin
        total = total + sums_model[p-1];
        p -= p & -p;
      end
      expected_totals.insert(expected_totals.size(), total);
    end
  endtask

  task automatic queue_cmd(input logic command, input int position,
                           input logic [ftb_pkg::SUM_W-1:0] amount);
    tree_cmd_t c;
    c.command = command;
    c.position = ftb_pkg::POS_W'(position);
    c.amount = amount;
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  // Amounts lean toward the wrap points and small signed values, which are
  // where carry and sign handling go wrong.
  function automatic logic [ftb_pkg::SUM_W-1:0] pick_amount();
    int roll;
    int small_val;
    roll = $urandom_range(0, 9);
    small_val = $urandom_range(0, 31);
    case (roll)
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3, 4: return ftb_pkg::SUM_W'(small_val - 16);
      default: return $urandom;
    endcase
  endfunction

  // Mostly positions inside the span; some at zero, at the span edge, and
  // anywhere in the 11-bit field so that clamping and ignored adds occur.
  function automatic int pick_position(input int span);
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0)
      return 0;
    if (roll == 1 || span == 0)
      return $urandom_range(0, 2047);
    if (roll == 2)
      return span;
    return $urandom_range(1, span);
  endfunction

  // Waits until every queued transaction is accepted and every expected total
  // has arrived, then lets any trailing add finish its walk. The queues are
  // looked at on the falling edge, after the driver's updates have settled.
  task automatic settle_tree();
    @(posedge clk);
    @(negedge clk);
    while (pending_cmds.size() != 0 || in_ch.valid || expected_totals.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Size writes happen only while the block is idle, so the model can follow
  // the write immediately.
  task automatic write_leaves(input logic [ftb_pkg::POS_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    leaves_model = value;
  endtask

  task automatic run_random_phase(input logic [ftb_pkg::POS_W-1:0] size, input int count,
                                  input int query_pct, input bit with_hold);
    int span;
    write_leaves(size);
    span = span_in_use();
    if (with_hold)
      pressure_requests++;
    for (int i = 0; i < count; i++) begin
      queue_cmd(($urandom_range(1, 100) <= query_pct) ? ftb_pkg::CMD_QUERY : ftb_pkg::CMD_ADD,
                pick_position(span), pick_amount());
    end
    settle_tree();
  endtask

  // Driver: offers queued transactions in bursts separated by random gaps.
  // The model is updated at the edge where a transaction is accepted.
  always @(posedge clk) begin : drive_proc
    tree_cmd_t accepted;
    tree_cmd_t next_cmd;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        accepted.command = in_ch.command;
        accepted.position = in_ch.position;
        accepted.amount = in_ch.amount;
        tree_apply(accepted);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          next_cmd = pending_cmds.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.command <= next_cmd.command;
          in_ch.position <= next_cmd.position;
          in_ch.amount <= next_cmd.amount;
          if (burst_left <= 1) begin
            // A quarter of the bursts run back to back with no gap after them.
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off on the result channel, counted here so that the receiver's
  // ordinary stall pattern carries on independently.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (pressure_served != pressure_requests) begin
      hold_left <= HOLD_CYCLES;
      pressure_served <= pressure_served + 1;
    end
  end

  // Monitor: checks every accepted result against the oldest expected total
  // and drives ready from a rotating stall pattern that is redrawn whenever
  // its age counter runs out; a quarter of the patterns never stall.
  always @(posedge clk) begin : sink_proc
    logic [ftb_pkg::SUM_W-1:0] want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_totals.size() == 0) begin
        report_mismatch($sformatf("prefix_total %0d with no query pending",
                                  $signed(out_ch.prefix_total)));
      end else begin
        want = expected_totals.pop_front();
        if (out_ch.prefix_total !== want)
          report_mismatch($sformatf("prefix_total got %0d expected %0d",
                                    $signed(out_ch.prefix_total), $signed(want)));
      end
    end
    if (stall_age == 0) begin
      stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      stall_age <= 63;
    end else begin
      stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
      stall_age <= stall_age - 1;
    end
    out_ch.ready <= (hold_left == 0) && stall_pattern[0];
  end

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_ch.valid = 1'b0;
    in_ch.command = ftb_pkg::CMD_ADD;
    in_ch.position = '0;
    in_ch.amount = '0;
    out_ch.ready = 1'b0;
    foreach (sums_model[i])
      sums_model[i] = '0;
    leaves_model = ftb_pkg::LEAVES_RESET;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset size. The block clears its table first and
    // holds off the input meanwhile, which the driver simply waits out.
    queue_cmd(ftb_pkg::CMD_QUERY, 0, 32'hDEAD_BEEF);   // query at zero, amount ignored
    queue_cmd(ftb_pkg::CMD_QUERY, TREE_LEAVES, '0);    // freshly cleared table
    queue_cmd(ftb_pkg::CMD_ADD, 1, 32'h7FFF_FFFF);
    queue_cmd(ftb_pkg::CMD_ADD, TREE_LEAVES, 32'h8000_0000);
    queue_cmd(ftb_pkg::CMD_ADD, 0, 32'd5);             // add at zero is dropped
    queue_cmd(ftb_pkg::CMD_ADD, 512, 32'hFFFF_FFFF);
    queue_cmd(ftb_pkg::CMD_ADD, 1023, 32'd1);
    queue_cmd(ftb_pkg::CMD_ADD, 2047, 32'd99);         // beyond the size, dropped
    queue_cmd(ftb_pkg::CMD_QUERY, 1, '0);
    queue_cmd(ftb_pkg::CMD_QUERY, 512, '0);
    queue_cmd(ftb_pkg::CMD_QUERY, 1023, '0);
    queue_cmd(ftb_pkg::CMD_QUERY, TREE_LEAVES, '0);
    queue_cmd(ftb_pkg::CMD_ADD, 1, 32'd1);             // wraps past the positive limit
    queue_cmd(ftb_pkg::CMD_QUERY, 1, 32'hFFFF_FFFF);
    queue_cmd(ftb_pkg::CMD_QUERY, 2047, '0);           // clamped to the size in use
    queue_cmd(ftb_pkg::CMD_QUERY, 1025, '0);
    queue_cmd(ftb_pkg::CMD_ADD, 683, 32'h5555_5555);
    queue_cmd(ftb_pkg::CMD_QUERY, 682, 32'h2AAA_AAAA);
    queue_cmd(ftb_pkg::CMD_QUERY, 683, '0);
    queue_cmd(ftb_pkg::CMD_QUERY, 0, '0);
    settle_tree();

    // Random phases over several sizes. The table is never cleared between
    // them, so each phase starts from whatever the previous one left behind.
    run_random_phase(11'd1024, 260, 50, 1'b0);
    run_random_phase(11'd1,     80, 50, 1'b0);
    run_random_phase(11'd2,     80, 50, 1'b0);
    run_random_phase(11'd0,     30, 50, 1'b0);   // no positions in use
    run_random_phase(11'd7,    150, 50, 1'b0);
    run_random_phase(11'd2047, 120, 50, 1'b0);   // acts as the full size
    run_random_phase(11'd513,  200, 50, 1'b0);
    run_random_phase(ftb_pkg::POS_W'($urandom_range(1, TREE_LEAVES)), 200, 50, 1'b0);
    // Query-heavy phase with a long stall on the result side, so a finished
    // query backs up into the input while the driver keeps offering.
    run_random_phase(11'd1024, 200, 80, 1'b1);
    run_random_phase(11'd100,  150, 50, 1'b0);
    run_random_phase(11'd1024, 150, 50, 1'b0);

    if (expected_totals.size() != 0)
      report_mismatch($sformatf("%0d prefix totals never arrived", expected_totals.size()));
    if (error_count == 0)
      $display("fenwick_tree_update_prefix_sum regression: pass");
    else
      $display("fenwick_tree_update_prefix_sum regression: fail");
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #5_000_000;
    $display("fenwick_tree_update_prefix_sum regression: fail");
    $finish;
  end

endmodule
